// File: sv/gray_floyd_steinberg_dither_unit_macros.svh
// assertion macros for the gray floyd-steinberg dither unit
`ifndef GRAY_FLOYD_STEINBERG_DITHER_UNIT_MACROS_SVH
`define GRAY_FLOYD_STEINBERG_DITHER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GFSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GFSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GFSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define GFSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/gfsd_pkg.sv
// shared constants and types of the gray floyd-steinberg dither unit
package gfsd_pkg;

    localparam int unsigned GFSD_MAX_WIDTH = 1024;
    localparam int unsigned GFSD_FRAC_BITS = 8;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 1'b0,
        REG_DITHER_ENABLE = 1'b1
    } t_cfg_reg;

    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST   = 11'd320;
    localparam logic                  DITHER_ENABLE_RST = 1'b1;

    localparam int unsigned GRAY_SUM_W = 13;
    localparam int GRAY_WR = 11;
    localparam int GRAY_WG = 16;
    localparam int GRAY_WB = 5;
    localparam int unsigned GRAY_SHIFT = 5;

    localparam int W_RIGHT      = 7;
    localparam int W_DOWN_LEFT  = 3;
    localparam int W_DOWN       = 5;
    localparam int W_DOWN_RIGHT = 1;
    localparam int unsigned SHARE_SHIFT = 4;

    localparam logic [PIX_W-1:0] LEVEL_BLACK = 8'h00;
    localparam logic [PIX_W-1:0] LEVEL_WHITE = 8'hFF;

endpackage

// File: sv/gray_floyd_steinberg_dither_unit.sv
// gray floyd-steinberg dither unit: gray conversion and error diffusion over a banked line store
// one pixel per cycle unless stalled; o_valid rises after the stage 1 and output registers
// throughput is set by the stage 1 error loop and one write per store bank per cycle
// the line store is split into even and odd banks with a one-entry tail buffer for row ends
// reset is synchronous; afterwards both banks are zeroed over (MAX_WIDTH+3)/2 entries (513 by
// default) with o_stall high; configuration writes are taken during that sweep
`include "gray_floyd_steinberg_dither_unit_macros.svh"

module gray_floyd_steinberg_dither_unit
    import gfsd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = GFSD_MAX_WIDTH,
    parameter int unsigned FRAC_BITS = GFSD_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_red,
    input  logic [PIX_W-1:0]      i_green,
    input  logic [PIX_W-1:0]      i_blue,
    input  logic                  i_start_of_image,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIX_W-1:0]      o_level,
    output logic                  o_end_of_row
);

    localparam int unsigned CW         = $clog2(MAX_WIDTH);
    localparam int unsigned WW         = $clog2(MAX_WIDTH + 1);
    localparam int unsigned AW         = $clog2(MAX_WIDTH + 2);
    localparam int unsigned BIW        = AW - 1;
    localparam int unsigned BANK_DEPTH = (MAX_WIDTH + 3) / 2;
    localparam int unsigned EW         = FRAC_BITS + 10;
    localparam int unsigned VW         = FRAC_BITS + 11;
    localparam int unsigned QW         = FRAC_BITS + 9;
    localparam int unsigned PW         = QW + 3;
    localparam logic signed [VW-1:0] V_TOP  = VW'(255 << FRAC_BITS);
    localparam logic signed [VW-1:0] V_HALF = VW'(255 << (FRAC_BITS - 1));

    // configuration
    logic [CFG_DATA_W-1:0] r_image_width;
    logic                  r_dither;

    // raster position
    logic [CW-1:0] r_column;
    logic          r_first_row;

    // store clearing sweep
    logic           r_clr_busy;
    logic [BIW-1:0] r_clr_idx;

    // line store banks
    logic signed [EW-1:0] r_mem0 [BANK_DEPTH];
    logic signed [EW-1:0] r_mem1 [BANK_DEPTH];
    logic signed [EW-1:0] r_rd0;
    logic signed [EW-1:0] r_rd1;

    // row-end tail entry
    logic                 r_tail_valid;
    logic [AW-1:0]        r_tail_addr;
    logic signed [EW-1:0] r_tail_data;

    // stage 1
    logic                 r_s1_valid;
    logic [PIX_W-1:0]     r_s1_gray;
    logic [CW-1:0]        r_s1_col;
    logic                 r_s1_last;
    logic                 r_s1_first;
    logic                 r_s1_soi;
    logic                 r_s1_rd_par;
    logic                 r_s1_fwd_hit;
    logic signed [EW-1:0] r_s1_fwd_data;

    // error carries
    logic signed [EW-1:0] r_right_carry;
    logic signed [EW-1:0] r_diag;
    logic signed [EW-1:0] r_below;

    // output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_level;
    logic             r_out_eor;

    logic                  accept;
    logic [WW-1:0]         w_eff;
    logic [CW-1:0]         c0;
    logic                  first0;
    logic                  last0;
    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [PIX_W-1:0]      gray0;
    logic [AW-1:0]         rd_addr0;
    logic                  fwd_hit0;
    logic signed [EW-1:0]  fwd_data0;

    logic                 s1_fire;
    logic                 px_we;
    logic signed [EW-1:0] rc_cur;
    logic signed [EW-1:0] diag_cur;
    logic signed [EW-1:0] below_cur;
    logic signed [EW-1:0] stored;
    logic signed [VW-1:0] v_sum;
    logic signed [VW-1:0] v_clamp;
    logic                 bin;
    logic signed [QW-1:0] q_err;
    logic signed [PW-1:0] e_x;
    logic signed [PW-1:0] p_right;
    logic signed [PW-1:0] p_dl;
    logic signed [PW-1:0] p_down;
    logic signed [PW-1:0] p_dr;
    logic signed [EW-1:0] s_right;
    logic signed [EW-1:0] s_dl;
    logic signed [EW-1:0] s_down;
    logic signed [EW-1:0] s_dr;
    logic signed [EW-1:0] wr_x;
    logic signed [EW-1:0] diag_new;
    logic signed [EW-1:0] below_new;
    logic [PIX_W-1:0]     level1;
    logic [AW-1:0]        x_addr;
    logic [AW-1:0]        x1_addr;
    logic [AW-1:0]        x2_addr;
    logic                 tail_commit;

    logic                 bk_we  [2];
    logic [BIW-1:0]       bk_idx [2];
    logic signed [EW-1:0] bk_wd  [2];

    // stage 0: raster position, gray level, store read address
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_image_width);
        end
        c0       = i_start_of_image ? '0 : r_column;
        first0   = i_start_of_image | r_first_row;
        last0    = (WW'(c0) + WW'(1)) >= w_eff;
        gray_sum = GRAY_SUM_W'(i_red) * GRAY_SUM_W'(GRAY_WR)
                 + GRAY_SUM_W'(i_green) * GRAY_SUM_W'(GRAY_WG)
                 + GRAY_SUM_W'(i_blue) * GRAY_SUM_W'(GRAY_WB);
        gray0    = gray_sum[GRAY_SHIFT +: PIX_W];
        rd_addr0 = AW'(c0) + AW'(1);
    end

    assign s1_fire = r_s1_valid & (~r_out_valid | ~i_stall);
    assign o_stall = r_clr_busy | (r_s1_valid & ~s1_fire);
    assign accept  = i_valid & ~o_stall;
    assign px_we   = s1_fire & r_dither;

    // stage 1: error loop
    always_comb begin
        rc_cur    = r_s1_soi ? '0 : r_right_carry;
        diag_cur  = r_s1_soi ? '0 : r_diag;
        below_cur = r_s1_soi ? '0 : r_below;
        if (r_s1_first) begin
            stored = '0;
        end else if (r_s1_fwd_hit) begin
            stored = r_s1_fwd_data;
        end else begin
            stored = r_s1_rd_par ? r_rd1 : r_rd0;
        end
        v_sum = $signed(VW'({r_s1_gray, {FRAC_BITS{1'b0}}})) + VW'(stored) + VW'(rc_cur);
        if (v_sum < 0) begin
            v_clamp = '0;
        end else if (v_sum > V_TOP) begin
            v_clamp = V_TOP;
        end else begin
            v_clamp = v_sum;
        end
        bin       = v_clamp >= V_HALF;
        q_err     = bin ? QW'(v_clamp - V_TOP) : QW'(v_clamp);
        e_x       = PW'(q_err);
        p_right   = e_x * PW'(W_RIGHT);
        p_dl      = e_x * PW'(W_DOWN_LEFT);
        p_down    = e_x * PW'(W_DOWN);
        p_dr      = e_x * PW'(W_DOWN_RIGHT);
        s_right   = EW'(p_right >>> SHARE_SHIFT);
        s_dl      = EW'(p_dl >>> SHARE_SHIFT);
        s_down    = EW'(p_down >>> SHARE_SHIFT);
        s_dr      = EW'(p_dr >>> SHARE_SHIFT);
        wr_x      = diag_cur + s_dl;
        diag_new  = below_cur + s_down;
        below_new = s_dr;
        if (r_dither) begin
            level1 = bin ? LEVEL_WHITE : LEVEL_BLACK;
        end else begin
            level1 = r_s1_gray;
        end
        x_addr  = AW'(r_s1_col);
        x1_addr = x_addr + AW'(1);
        x2_addr = x_addr + AW'(2);
    end

    // tail entry goes out on a bank that no pixel write uses this cycle
    assign tail_commit = r_tail_valid & ~r_clr_busy
                       & ~(px_we & ((x_addr[0] == r_tail_addr[0])
                                    | (r_s1_last & (x1_addr[0] == r_tail_addr[0]))));

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            bk_we[b]  = 1'b0;
            bk_idx[b] = r_tail_addr[AW-1:1];
            bk_wd[b]  = r_tail_data;
            if (r_clr_busy) begin
                bk_we[b]  = 1'b1;
                bk_idx[b] = r_clr_idx;
                bk_wd[b]  = '0;
            end else if (px_we && (x_addr[0] == 1'(b))) begin
                bk_we[b]  = 1'b1;
                bk_idx[b] = x_addr[AW-1:1];
                bk_wd[b]  = wr_x;
            end else if (px_we && r_s1_last && (x1_addr[0] == 1'(b))) begin
                bk_we[b]  = 1'b1;
                bk_idx[b] = x1_addr[AW-1:1];
                bk_wd[b]  = diag_new;
            end else if (tail_commit && (r_tail_addr[0] == 1'(b))) begin
                bk_we[b]  = 1'b1;
            end
        end
    end

    // forwarding of writes the store read cannot see yet
    always_comb begin
        fwd_hit0  = 1'b0;
        fwd_data0 = r_tail_data;
        if (px_we && (rd_addr0 == x_addr)) begin
            fwd_hit0  = 1'b1;
            fwd_data0 = wr_x;
        end else if (px_we && r_s1_last && (rd_addr0 == x1_addr)) begin
            fwd_hit0  = 1'b1;
            fwd_data0 = diag_new;
        end else if (px_we && r_s1_last && (rd_addr0 == x2_addr)) begin
            fwd_hit0  = 1'b1;
            fwd_data0 = below_new;
        end else if (r_tail_valid && (rd_addr0 == r_tail_addr)) begin
            fwd_hit0  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bk_we[0]) begin
            r_mem0[bk_idx[0]] <= bk_wd[0];
        end
        if (bk_we[1]) begin
            r_mem1[bk_idx[1]] <= bk_wd[1];
        end
        if (accept) begin
            r_rd0 <= r_mem0[rd_addr0[AW-1:1]];
            r_rd1 <= r_mem1[rd_addr0[AW-1:1]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IMAGE_WIDTH_RST;
            r_dither      <= DITHER_ENABLE_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH:   r_image_width <= i_cfg_data;
                REG_DITHER_ENABLE: r_dither      <= i_cfg_data[0];
                default:           r_dither      <= r_dither;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == BIW'(BANK_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + BIW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_first_row <= 1'b1;
            r_s1_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_column    <= last0 ? '0 : c0 + CW'(1);
                r_first_row <= last0 ? 1'b0 : first0;
                r_s1_valid  <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_gray     <= gray0;
            r_s1_col      <= c0;
            r_s1_last     <= last0;
            r_s1_first    <= first0;
            r_s1_soi      <= i_start_of_image;
            r_s1_rd_par   <= rd_addr0[0];
            r_s1_fwd_hit  <= fwd_hit0;
            r_s1_fwd_data <= fwd_data0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_carry <= '0;
            r_diag        <= '0;
            r_below       <= '0;
        end else if (s1_fire) begin
            if (r_dither) begin
                r_right_carry <= r_s1_last ? '0 : s_right;
                r_diag        <= r_s1_last ? '0 : diag_new;
                r_below       <= r_s1_last ? '0 : below_new;
            end else if (r_s1_soi) begin
                r_right_carry <= '0;
                r_diag        <= '0;
                r_below       <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_valid <= 1'b0;
        end else if (px_we && r_s1_last) begin
            r_tail_valid <= 1'b1;
            r_tail_addr  <= x2_addr;
            r_tail_data  <= below_new;
        end else if (tail_commit) begin
            r_tail_valid <= 1'b0;
        end else if (px_we && (x_addr == r_tail_addr)) begin
            r_tail_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_level <= level1;
            r_out_eor   <= r_s1_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_level      = r_out_level;
    assign o_end_of_row = r_out_eor;

    `GFSD_ASSERT_NOW(a_clear_quiet, i_clk, i_rst_n, r_clr_busy, !r_s1_valid && !r_out_valid, "pixel in flight during store clear")
    `GFSD_ASSERT_NEXT(a_dither_binary, i_clk, i_rst_n, s1_fire && r_dither, r_out_level == LEVEL_BLACK || r_out_level == LEVEL_WHITE, "dithered level not binary")
    `GFSD_ASSERT_NOW(a_tail_bank_free, i_clk, i_rst_n, tail_commit && px_we, !r_s1_last && (r_tail_addr[0] != x_addr[0]), "tail write collides with pixel write")

endmodule

// File: bench/gray_floyd_steinberg_dither_unit_test.sv
// self-checking bench for the gray floyd-steinberg dither unit: directed table, random images
module gray_floyd_steinberg_dither_unit_test;
    import gfsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW        = GFSD_MAX_WIDTH;
    localparam int ONE_FIX     = 1 << GFSD_FRAC_BITS;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [17:0] t_err;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             sol;
    } t_pixel;

    typedef struct {
        logic [PIX_W-1:0] level;
        logic             eor;
    } t_beat;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        t_cfg_reg              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_pixel                px;
        bit                    typed;
        t_beat                 beat;
    } t_dir_row;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  i_valid          = 1'b0;
    logic                  o_stall;
    logic [PIX_W-1:0]      i_red            = '0;
    logic [PIX_W-1:0]      i_green          = '0;
    logic [PIX_W-1:0]      i_blue           = '0;
    logic                  i_start_of_image = 1'b0;
    logic                  o_valid;
    logic                  i_stall          = 1'b0;
    logic [PIX_W-1:0]      o_level;
    logic                  o_end_of_row;

    gray_floyd_steinberg_dither_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_start_of_image (i_start_of_image),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_level          (o_level),
        .o_end_of_row     (o_end_of_row)
    );

    // predictor state
    t_err                  err_line [0:MAXW+1];
    t_err                  carry_right;
    t_err                  pend_diag;
    t_err                  pend_below;
    int                    col_pos;
    bit                    in_first_row;
    logic [CFG_DATA_W-1:0] cfg_width;
    logic                  cfg_dither;

    t_beat    pending_levels [$];
    t_dir_row dir_rows [$];

    int error_count    = 0;
    int cycle_count    = 0;
    int pixel_count    = 0;
    int image_count    = 0;
    int row_end_count  = 0;
    int phase_count    = 0;
    int hold_count     = 0;
    int hold_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit pressure_on    = 1'b0;
    int rows_left      = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                     pending_levels.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stalls plus long hold-offs under pressure
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            i_stall     <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (pressure_on && (hold_count == 0 || $urandom_range(0, 59) == 0)) begin
            i_stall     <= 1'b1;
            hold_cycles <= $urandom_range(40, 120);
            hold_count  <= hold_count + 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 100)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic void queue_beat(input t_beat beat);
        pending_levels.insert(pending_levels.size(), beat);
    endfunction

    function automatic void queue_row(input t_dir_row row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (o_end_of_row)
                row_end_count++;
            if (pending_levels.size() == 0) begin
                report_mismatch("output beat with nothing expected");
            end else begin
                want = pending_levels.pop_front();
                if (o_level !== want.level)
                    report_mismatch($sformatf("level %0d, expected %0d", o_level, want.level));
                if (o_end_of_row !== want.eor)
                    report_mismatch($sformatf("end_of_row %0b, expected %0b", o_end_of_row,
                                              want.eor));
            end
        end
    end

    function automatic int err_share(input int e, input int k);
        return (e * k) >>> 4;
    endfunction

    task automatic predict_dither(input t_pixel px, output t_beat res);
        int gray;
        int w;
        int x;
        int stored;
        int v;
        int e;
        int top;
        bit last;
        gray = (int'(px.red) * 11 + int'(px.green) * 16 + int'(px.blue) * 5) / 32;
        w = int'(cfg_width);
        if (w == 0)
            w = 1;
        if (w > MAXW)
            w = MAXW;
        if (px.sol) begin
            col_pos      = 0;
            carry_right  = '0;
            pend_diag    = '0;
            pend_below   = '0;
            in_first_row = 1'b1;
        end
        if (col_pos >= MAXW)
            col_pos = MAXW - 1;
        x    = col_pos;
        last = (x + 1 >= w);
        res.level = gray[7:0];
        res.eor   = last;
        if (cfg_dither) begin
            top    = 255 * ONE_FIX;
            stored = in_first_row ? 0 : int'(err_line[x+1]);
            v      = gray * ONE_FIX + stored + int'(carry_right);
            if (v < 0)
                v = 0;
            if (v > top)
                v = top;
            if (v < top / 2) begin
                res.level = LEVEL_BLACK;
                e = v;
            end else begin
                res.level = LEVEL_WHITE;
                e = v - top;
            end
            err_line[x] = t_err'(int'(pend_diag) + err_share(e, 3));
            pend_diag   = t_err'(int'(pend_below) + err_share(e, 5));
            pend_below  = t_err'(err_share(e, 1));
            carry_right = t_err'(err_share(e, 7));
            if (last) begin
                err_line[x+1] = pend_diag;
                err_line[x+2] = pend_below;
                carry_right   = '0;
                pend_diag     = '0;
                pend_below    = '0;
            end
        end
        if (last) begin
            col_pos      = 0;
            in_first_row = 1'b0;
        end else begin
            col_pos = x + 1;
        end
    endtask

    task automatic drive_pixel(input t_pixel px, input bit typed, input t_beat typed_beat);
        t_beat pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_red            <= px.red;
        i_green          <= px.green;
        i_blue           <= px.blue;
        i_start_of_image <= px.sol;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predict_dither(px, pred);
        if (typed)
            pred = typed_beat;
        queue_beat(pred);
        pixel_count++;
        if (px.sol)
            image_count++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            REG_IMAGE_WIDTH:   cfg_width  = val;
            REG_DITHER_ENABLE: cfg_dither = val[0];
            default: ;
        endcase
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic phase_cfg(input int width, input int dith);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(width));
        write_reg(REG_DITHER_ENABLE, CFG_DATA_W'(dith));
    endtask

    task automatic run_phase(input int count, input int send_pct, input int recv_pct,
                             input bit squeeze);
        t_pixel px;
        t_beat  none;
        int     pick;
        none           = '{level: '0, eor: 1'b0};
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        pressure_on    = squeeze;
        rows_left      = 0;
        phase_count++;
        repeat (count) begin
            pick     = $urandom_range(0, 9);
            px.red   = PIX_W'($urandom_range(0, 255));
            px.green = PIX_W'($urandom_range(0, 255));
            px.blue  = PIX_W'($urandom_range(0, 255));
            if (pick == 0) begin
                px.red = '0; px.green = '0; px.blue = '0;
            end else if (pick == 1) begin
                px.red = '1; px.green = '1; px.blue = '1;
            end else if (pick == 2) begin
                px.red   = PIX_W'(127 + $urandom_range(0, 1));
                px.green = px.red;
                px.blue  = px.red;
            end
            px.sol = 1'b0;
            if (col_pos == 0 && rows_left == 0) begin
                px.sol    = 1'b1;
                rows_left = $urandom_range(1, 4);
            end else if ($urandom_range(0, 39) == 0) begin
                px.sol = 1'b1;
            end
            drive_pixel(px, 1'b0, none);
            if (col_pos == 0 && rows_left > 0)
                rows_left--;
        end
        wait_idle();
        pressure_on    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    function automatic t_dir_row pix_row(input int r, input int g, input int b,
                                         input bit sol, input bit typed = 1'b0,
                                         input logic [PIX_W-1:0] lvl = '0,
                                         input bit eor = 1'b0);
        t_dir_row row;
        row.kind    = ROW_PIXEL;
        row.reg_idx = REG_IMAGE_WIDTH;
        row.reg_val = '0;
        row.px      = '{red: PIX_W'(r), green: PIX_W'(g), blue: PIX_W'(b), sol: sol};
        row.typed   = typed;
        row.beat    = '{level: lvl, eor: eor};
        return row;
    endfunction

    function automatic t_dir_row reg_row(input t_cfg_reg idx, input int val);
        t_dir_row row;
        row         = pix_row(0, 0, 0, 1'b0);
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = CFG_DATA_W'(val);
        return row;
    endfunction

    initial begin
        foreach (err_line[i])
            err_line[i] = '0;
        carry_right  = '0;
        pend_diag    = '0;
        pend_below   = '0;
        col_pos      = 0;
        in_first_row = 1'b1;
        cfg_width    = IMAGE_WIDTH_RST;
        cfg_dither   = DITHER_ENABLE_RST;

        // plain gray, one-pixel rows
        queue_row(reg_row(REG_IMAGE_WIDTH, 1));
        queue_row(reg_row(REG_DITHER_ENABLE, 0));
        queue_row(pix_row(255, 255, 255, 1'b1, 1'b1, 8'd255, 1'b1));
        queue_row(pix_row(0, 0, 0, 1'b0, 1'b1, 8'd0, 1'b1));
        queue_row(pix_row(255, 0, 0, 1'b0, 1'b1, 8'd87, 1'b1));
        queue_row(pix_row(0, 255, 0, 1'b0, 1'b1, 8'd127, 1'b1));
        queue_row(pix_row(0, 0, 255, 1'b0, 1'b1, 8'd39, 1'b1));
        // zero width acts as one, dithering on
        queue_row(reg_row(REG_IMAGE_WIDTH, 0));
        queue_row(reg_row(REG_DITHER_ENABLE, 1));
        queue_row(pix_row(255, 255, 255, 1'b1, 1'b1, LEVEL_WHITE, 1'b1));
        queue_row(pix_row(0, 0, 0, 1'b1, 1'b1, LEVEL_BLACK, 1'b1));
        queue_row(pix_row(127, 127, 127, 1'b0));
        queue_row(pix_row(128, 128, 128, 1'b0));
        // oversized width, then lowered mid-row
        queue_row(reg_row(REG_IMAGE_WIDTH, 2047));
        queue_row(pix_row(127, 127, 127, 1'b1));
        queue_row(pix_row(200, 100, 50, 1'b0));
        queue_row(pix_row(128, 128, 128, 1'b0));
        queue_row(reg_row(REG_IMAGE_WIDTH, 2));
        queue_row(pix_row(60, 60, 60, 1'b0));
        // three-wide rows, restart mid-row
        queue_row(reg_row(REG_IMAGE_WIDTH, 3));
        queue_row(pix_row(127, 127, 127, 1'b1));
        queue_row(pix_row(127, 127, 127, 1'b0));
        queue_row(pix_row(0, 0, 0, 1'b0));
        queue_row(pix_row(255, 255, 255, 1'b0));
        queue_row(pix_row(90, 160, 30, 1'b1));
        queue_row(pix_row(127, 127, 127, 1'b0));
        queue_row(pix_row(255, 0, 255, 1'b0));
        queue_row(pix_row(100, 140, 120, 1'b0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                drive_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].beat);
            end
        end
        wait_idle();

        phase_cfg(5, 1);
        run_phase(120, 0, 0, 1'b0);
        phase_cfg(1, 1);
        run_phase(100, 46, 0, 1'b0);
        phase_cfg(2, 0);
        run_phase(100, 0, 46, 1'b0);
        phase_cfg($urandom_range(3, 40), 1);
        run_phase(180, 28, 28, 1'b0);
        phase_cfg(17, 1);
        run_phase(150, 0, 0, 1'b1);
        phase_cfg($urandom_range(1, 64), $urandom_range(0, 1));
        run_phase(180, 28, 28, 1'b0);
        phase_cfg(3, 1);
        run_phase(180, 46, 46, 1'b0);
        phase_cfg(MAXW, 1);
        run_phase(60, 0, 0, 1'b0);

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("covered %0d pixels over %0d random phases, %0d images, %0d row ends",
                 pixel_count, phase_count, image_count, row_end_count);
        $display("receiver hold-offs: %0d, mismatches: %0d", hold_count, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
